/* design/twa_pkg.sv */
// ----------------------------------------------------------------------------
// twa_pkg: shared types and helpers for the ternary word ALU
// Opcodes, lane geometry, the per-lane result record and small trit functions.
// ----------------------------------------------------------------------------
package twa_pkg;

  // Word geometry: the word is cut into equal lanes of trits.
  localparam int MAX_TRITS  = 32;
  localparam int LANE_TRITS = 8;
  localparam int NUM_LANES  = MAX_TRITS / LANE_TRITS;
  localparam int WORD_BITS  = 2 * MAX_TRITS;
  localparam int LANE_BITS  = 2 * LANE_TRITS;
  localparam int WIDTH_BITS = 6;

  // Trit codes of the unbalanced encoding.
  localparam logic [1:0] TRIT_NEG  = 2'd0;
  localparam logic [1:0] TRIT_ZERO = 2'd1;
  localparam logic [1:0] TRIT_POS  = 2'd2;

  // Opcodes.
  typedef enum logic [3:0] {
    OP_PASS  = 4'd0,
    OP_OR    = 4'd1,
    OP_NOR   = 4'd2,
    OP_AND   = 4'd3,
    OP_NAND  = 4'd4,
    OP_XOR   = 4'd5,
    OP_BSUBA = 4'd6,
    OP_ASUBB = 4'd7,
    OP_ADD   = 4'd8
  } twa_op_e;

  // Result of one lane; first, second, cout and az are indexed by carry-in (0 or 1).
  typedef struct packed {
    logic [1:0][LANE_BITS-1:0] first;
    logic [1:0][LANE_BITS-1:0] second;
    logic [1:0]                cout;
    logic [1:0][1:0]           az;
    logic [1:0]                par_a;
    logic [1:0]                par_b;
  } twa_lane_t;

  // Per-item control carried alongside the lane results.
  typedef struct packed {
    logic                  cin;
    logic                  arith;
    logic [WIDTH_BITS-1:0] width;
  } twa_ctl_t;

  typedef struct packed {
    logic [1:0] sum;
    logic       carry;
  } twa_fa_t;

  // Code 3 is unused; it is read as the positive trit.
  function automatic logic [1:0] trit_sat(input logic [1:0] c);
    return (c == 2'd3) ? TRIT_POS : c;
  endfunction

  // Sum of two trit codes modulo 3.
  function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  // Ternary full adder on codes; the carry is always 0 or 1.
  function automatic twa_fa_t full_add(input logic [1:0] a, input logic [1:0] b,
                                       input logic cin);
    logic [2:0] s;
    logic [2:0] t;
    twa_fa_t    r;
    s = {1'b0, a} + {1'b0, b};
    t = ((s >= 3'd3) ? (s - 3'd3) : s) + {2'b00, cin};
    r.sum   = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    r.carry = (s >= 3'd3) || (t >= 3'd3);
    return r;
  endfunction

endpackage

/* design/twa_lane.sv */
// ----------------------------------------------------------------------------
// twa_lane: one lane of trits
// Computes the logic and arithmetic results of its trits for both possible
// carry-ins, plus the lane's partial flags, and registers them.
// ----------------------------------------------------------------------------
module twa_lane (
  input  logic                          clk_i,
  input  logic [3:0]                    req_type_i,
  input  logic [twa_pkg::LANE_BITS-1:0]  a_i,
  input  logic [twa_pkg::LANE_BITS-1:0]  b_i,
  input  logic [twa_pkg::WIDTH_BITS-1:0] width_i,
  input  logic [twa_pkg::WIDTH_BITS-1:0] base_i,
  output twa_pkg::twa_lane_t             res_o
);
  import twa_pkg::*;

  twa_lane_t res_d;
  twa_lane_t res_q;

  // Ripple through the lane once per carry-in; unused trits read zero.
  always_comb begin
    logic [1:0]            ta;
    logic [1:0]            tb;
    logic [1:0]            f;
    logic [1:0]            s;
    logic [1:0]            mx;
    logic [1:0]            mn;
    logic [1:0]            az;
    logic                  c;
    logic                  used;
    logic [WIDTH_BITS-1:0] idx;
    twa_fa_t               fa;
    res_d = '0;
    for (int v = 0; v < 2; v++) begin
      c  = v[0];
      az = TRIT_NEG;
      for (int j = 0; j < LANE_TRITS; j++) begin
        ta   = trit_sat(a_i[2*j +: 2]);
        tb   = trit_sat(b_i[2*j +: 2]);
        idx  = base_i + WIDTH_BITS'(j);
        used = idx < width_i;
        mx   = (ta > tb) ? ta : tb;
        mn   = (ta < tb) ? ta : tb;
        fa   = '0;
        f    = TRIT_ZERO;
        s    = TRIT_ZERO;
        unique case (twa_op_e'(req_type_i))
          OP_PASS: begin
            f = ta;
            s = tb;
          end
          OP_OR, OP_NOR: begin
            f = mx;
            s = TRIT_POS - mx;
          end
          OP_AND, OP_NAND: begin
            f = mn;
            s = TRIT_POS - mn;
          end
          OP_XOR: begin
            f = add_mod3(ta, tb);
            s = (ta == tb) ? TRIT_NEG : ((ta > tb) ? TRIT_ZERO : TRIT_POS);
          end
          OP_BSUBA: begin
            fa = full_add(TRIT_POS - ta, tb, c);
            f  = fa.sum;
            s  = {1'b0, fa.carry};
          end
          OP_ASUBB: begin
            fa = full_add(ta, TRIT_POS - tb, c);
            f  = fa.sum;
            s  = {1'b0, fa.carry};
          end
          OP_ADD: begin
            fa = full_add(ta, tb, c);
            f  = fa.sum;
            s  = {1'b0, fa.carry};
          end
          default: begin
            f = TRIT_ZERO;
            s = TRIT_ZERO;
          end
        endcase
        if (used) begin
          c = fa.carry;
          if (f > az) begin
            az = f;
          end
        end else begin
          f = TRIT_ZERO;
          s = TRIT_ZERO;
        end
        res_d.first[v][2*j +: 2]  = f;
        res_d.second[v][2*j +: 2] = s;
      end
      res_d.cout[v] = c;
      res_d.az[v]   = az;
    end
    // Partial parities over the used trits.
    for (int j = 0; j < LANE_TRITS; j++) begin
      idx = base_i + WIDTH_BITS'(j);
      if (idx < width_i) begin
        res_d.par_a = add_mod3(res_d.par_a, trit_sat(a_i[2*j +: 2]));
        res_d.par_b = add_mod3(res_d.par_b, trit_sat(b_i[2*j +: 2]));
      end
    end
  end

  // Lane result register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* design/twa_merge.sv */
// ----------------------------------------------------------------------------
// twa_merge: lane merge stage
// Runs the carry across the lanes to pick each lane's variant, then builds
// the result words, the overflow and the flags, and registers them.
// ----------------------------------------------------------------------------
module twa_merge (
  input  logic                            clk_i,
  input  twa_pkg::twa_lane_t [twa_pkg::NUM_LANES-1:0] lane_i,
  input  twa_pkg::twa_ctl_t               ctl_i,
  output logic [twa_pkg::WORD_BITS-1:0]    first_word_o,
  output logic [twa_pkg::WORD_BITS-1:0]    second_word_o,
  output logic [1:0]                      overflow_trit_o,
  output logic [1:0]                      max_trit_o,
  output logic [1:0]                      parity_a_trit_o,
  output logic [1:0]                      parity_b_trit_o,
  output logic [twa_pkg::WIDTH_BITS-1:0]   used_width_o
);
  import twa_pkg::*;

  logic [WORD_BITS-1:0]  first_d, first_q;
  logic [WORD_BITS-1:0]  second_d, second_q;
  logic [1:0]            ovf_d, ovf_q;
  logic [1:0]            az_d, az_q;
  logic [1:0]            pa_d, pa_q;
  logic [1:0]            pb_d, pb_q;
  logic [WIDTH_BITS-1:0] width_q;

  // Carry select across the lanes and flag reduction.
  always_comb begin
    logic c;
    c     = ctl_i.cin;
    az_d  = TRIT_NEG;
    pa_d  = TRIT_NEG;
    pb_d  = TRIT_NEG;
    first_d  = '0;
    second_d = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      first_d[l*LANE_BITS +: LANE_BITS]  = lane_i[l].first[c];
      second_d[l*LANE_BITS +: LANE_BITS] = lane_i[l].second[c];
      if (lane_i[l].az[c] > az_d) begin
        az_d = lane_i[l].az[c];
      end
      pa_d = add_mod3(pa_d, lane_i[l].par_a);
      pb_d = add_mod3(pb_d, lane_i[l].par_b);
      c    = lane_i[l].cout[c];
    end
    ovf_d = ctl_i.arith ? {1'b0, c} : TRIT_ZERO;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    ovf_q    <= ovf_d;
    az_q     <= az_d;
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    width_q  <= ctl_i.width;
  end

  assign first_word_o    = first_q;
  assign second_word_o   = second_q;
  assign overflow_trit_o = ovf_q;
  assign max_trit_o      = az_q;
  assign parity_a_trit_o = pa_q;
  assign parity_b_trit_o = pb_q;
  assign used_width_o    = width_q;

endmodule

/* design/ternary_word_alu.sv */
// ----------------------------------------------------------------------------
// ternary_word_alu: ALU for words of up to 32 unbalanced trits
// Lane-parallel logic and carry-select arithmetic with a registered merge.
// ----------------------------------------------------------------------------
// Usage:
// An item is presented on req_type_i, operand_a_i, operand_b_i and
// word_width_i and is taken at a rising edge where start is high and busy
// is low. busy is never raised, so a new item may be given every cycle.
// Each result appears on the output ports for one cycle, marked by valid_o,
// once its item has passed the lane and merge registers. Throughput is one
// item per cycle and results come out in the order the items went in.
// The lane stage runs four 8-trit lanes side by side, each computing its
// ripple for both carry-ins; the merge stage walks the carry across the
// four lanes to select results and merges the flags. The lane ripple of
// eight trits sets the clock-to-clock path.
// Reset clears the valid pipeline, so no result appears out of reset.
// The receiver cannot stall; results must be taken when valid_o is high.
// ----------------------------------------------------------------------------
module ternary_word_alu (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [3:0]                     req_type_i,
  input  logic [twa_pkg::WORD_BITS-1:0]   operand_a_i,
  input  logic [twa_pkg::WORD_BITS-1:0]   operand_b_i,
  input  logic [twa_pkg::WIDTH_BITS-1:0]  word_width_i,
  output logic                           valid_o,
  output logic [twa_pkg::WORD_BITS-1:0]   first_word_o,
  output logic [twa_pkg::WORD_BITS-1:0]   second_word_o,
  output logic [1:0]                     overflow_trit_o,
  output logic [1:0]                     max_trit_o,
  output logic [1:0]                     parity_a_trit_o,
  output logic [1:0]                     parity_b_trit_o,
  output logic [twa_pkg::WIDTH_BITS-1:0]  used_width_o
);
  import twa_pkg::*;

  logic [WIDTH_BITS-1:0]           width_c;
  twa_op_e                         op_c;
  twa_ctl_t                        ctl_d, ctl_q;
  twa_lane_t [NUM_LANES-1:0]       lane_res;
  logic                            v1_q, v2_q;
  logic                            accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op_c   = twa_op_e'(req_type_i);

  // Clamp the width to 1..MAX_TRITS.
  always_comb begin
    if (word_width_i == '0) begin
      width_c = WIDTH_BITS'(1);
    end else if (word_width_i > WIDTH_BITS'(MAX_TRITS)) begin
      width_c = WIDTH_BITS'(MAX_TRITS);
    end else begin
      width_c = word_width_i;
    end
  end

  // Control that follows the item into the merge stage.
  always_comb begin
    ctl_d.width = width_c;
    ctl_d.cin   = (op_c == OP_BSUBA) || (op_c == OP_ASUBB);
    ctl_d.arith = (op_c == OP_BSUBA) || (op_c == OP_ASUBB) || (op_c == OP_ADD);
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_d;
  end

  // Valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  // Lanes.
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    twa_lane u_lane (
      .clk_i      (clk_i),
      .req_type_i (req_type_i),
      .a_i        (operand_a_i[l*LANE_BITS +: LANE_BITS]),
      .b_i        (operand_b_i[l*LANE_BITS +: LANE_BITS]),
      .width_i    (width_c),
      .base_i     (WIDTH_BITS'(l * LANE_TRITS)),
      .res_o      (lane_res[l])
    );
  end

  // Merge stage.
  twa_merge u_merge (
    .clk_i           (clk_i),
    .lane_i          (lane_res),
    .ctl_i           (ctl_q),
    .first_word_o    (first_word_o),
    .second_word_o   (second_word_o),
    .overflow_trit_o (overflow_trit_o),
    .max_trit_o      (max_trit_o),
    .parity_a_trit_o (parity_a_trit_o),
    .parity_b_trit_o (parity_b_trit_o),
    .used_width_o    (used_width_o)
  );

  assign valid_o = v2_q;

  // Every accepted item gives a result once it has passed v1_q and v2_q.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 valid_o)
    else $error("accepted item produced no result");

  // No result appears without an accepted item.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##2 !valid_o)
    else $error("result without an accepted item");

  // The applied width always lies in 1..MAX_TRITS.
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (used_width_o != '0) && (used_width_o <= WIDTH_BITS'(MAX_TRITS)))
    else $error("applied width out of range");

  // Flag trits never carry the unused code.
  a_flag_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (overflow_trit_o != 2'd3) && (max_trit_o != 2'd3)
                && (parity_a_trit_o != 2'd3) && (parity_b_trit_o != 2'd3))
    else $error("flag trit holds code 3");

endmodule
